// ===== rtl/core/ctrq_pkg.sv =====
// ----------------------------------------------------------------------------
// ctrq_pkg
// Shared types, codes and the charge cost table of the credit-throttled
// request queue.
// ----------------------------------------------------------------------------
package ctrq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int ID_W       = 8;
	localparam int BUDGET_W   = 16;
	localparam int DECAY_W    = 8;
	localparam int TIME_W     = 32;
	localparam int NODES_W    = 8;
	localparam int STATUS_W   = 3;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam int DRAIN_W    = TIME_W + DECAY_W;
	localparam int COST_W     = 10;

	localparam logic [BUDGET_W-1:0] BUDGET_LIMIT_RST = 16'd68;
	localparam logic [DECAY_W-1:0]  DECAY_RST        = 8'd1;

	// Nodes per cost band and the number of bands.
	localparam int BAND_STEP = 10;
	localparam int BAND_NUM  = 17;

	localparam logic [CFG_ADDR_W-1:0] CFG_BUDGET_LIMIT = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_DECAY_PER_MS = 1'd1;

	typedef enum logic [1:0] {
		MODE_REQUEST = 2'd0,
		MODE_TICK    = 2'd1,
		MODE_CHARGE  = 2'd2,
		MODE_CANCEL  = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_NONE      = 3'd0,
		ST_GRANTED   = 3'd1,
		ST_QUEUED    = 3'd2,
		ST_DUPLICATE = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	// Command broadcast from the controller to every cell of the chain.
	typedef struct packed {
		logic            shift;
		logic            wrap_kill;
		logic            load;
		logic [ID_W-1:0] load_id;
	} cell_cmd_t;

	localparam logic [7:0] BAND_COST [BAND_NUM] = '{
		8'd2, 8'd4, 8'd8, 8'd13, 8'd19, 8'd26, 8'd34, 8'd43, 8'd53,
		8'd64, 8'd76, 8'd89, 8'd103, 8'd118, 8'd134, 8'd151, 8'd169
	};

	// Banded cost in quarter units. The band is the number of band
	// boundaries that the node count lies above, held at the last band.
	function automatic logic [COST_W-1:0] charge_cost(input logic [NODES_W-1:0] nodes);
		logic [4:0] band;
		band = '0;
		for (int b = 1; b < BAND_NUM; b++) begin
			if (int'(nodes) > b * BAND_STEP)
				band = band + 5'd1;
		end
		return {BAND_COST[band], 2'b00};
	endfunction

endpackage

// ===== rtl/core/ctrq_cell.sv =====
// ----------------------------------------------------------------------------
// ctrq_cell
// One slot of the request chain: a requester id and its live bit. On a shift
// the slot takes its neighbor's contents; a load writes a new tail entry.
// ----------------------------------------------------------------------------
module ctrq_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ctrq_pkg::cell_cmd_t         cmd,
	input  logic                        sel,
	input  logic [ctrq_pkg::ID_W-1:0]   nb_id,
	input  logic                        nb_live,
	input  logic                        nb_kill,
	output logic [ctrq_pkg::ID_W-1:0]   id,
	output logic                        live
);

	logic [ctrq_pkg::ID_W-1:0] id_q;
	logic                      live_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else if (cmd.load && sel) begin
			live_q <= 1'b1;
		end else if (cmd.shift) begin
			live_q <= nb_live & ~nb_kill;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && sel) begin
			id_q <= cmd.load_id;
		end else if (cmd.shift) begin
			id_q <= nb_id;
		end
	end

	assign id   = id_q;
	assign live = live_q;

endmodule

// ===== rtl/core/ctrq_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctrq_ctrl
// Sequencer of the request queue: budget, tick time, queue fill count and
// configuration. It walks the cell chain one slot per cycle through its head.
// ----------------------------------------------------------------------------
module ctrq_ctrl #(
	parameter int QUEUE_DEPTH = ctrq_pkg::QUEUE_DEPTH_DEF,
	parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        mode,
	input  logic [ctrq_pkg::ID_W-1:0]         requester_id,
	input  logic [ctrq_pkg::TIME_W-1:0]       now_ms,
	input  logic [ctrq_pkg::NODES_W-1:0]      nodes_used,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ctrq_pkg::STATUS_W-1:0]     status,
	output logic [ctrq_pkg::ID_W-1:0]         granted_id,
	input  logic                              cfg_we,
	input  logic [ctrq_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [ctrq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic [ctrq_pkg::ID_W-1:0]         head_id,
	input  logic                              head_live,
	output ctrq_pkg::cell_cmd_t               cmd,
	output logic [CW-1:0]                     count
);

	localparam int SW = $clog2(QUEUE_DEPTH);
	localparam logic [SW-1:0] SCAN_LAST = SW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] COUNT_FULL = CW'(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_ENQ,
		S_DRAIN,
		S_SKIP,
		S_DONE
	} state_t;

	state_t                               state_q;
	ctrq_pkg::mode_t                      mode_q;
	logic [ctrq_pkg::ID_W-1:0]            rid_q;
	logic [ctrq_pkg::TIME_W-1:0]          now_q;
	logic [ctrq_pkg::NODES_W-1:0]         nodes_q;
	logic [ctrq_pkg::TIME_W-1:0]          last_tick_q;
	logic [ctrq_pkg::BUDGET_W-1:0]        budget_q;
	logic [ctrq_pkg::BUDGET_W-1:0]        limit_q;
	logic [ctrq_pkg::DECAY_W-1:0]         decay_q;
	logic [ctrq_pkg::DRAIN_W-1:0]         drain_s1;
	logic [CW-1:0]                        count_q;
	logic [SW-1:0]                        scan_q;
	logic                                 dup_q;
	ctrq_pkg::status_t                    res_status_q;
	logic [ctrq_pkg::ID_W-1:0]            res_gid_q;
	logic                                 out_valid_q;
	ctrq_pkg::status_t                    out_status_q;
	logic [ctrq_pkg::ID_W-1:0]            out_gid_q;

	logic                                 head_hit;
	logic [ctrq_pkg::BUDGET_W:0]          charge_sum;
	logic [ctrq_pkg::BUDGET_W-1:0]        charged;
	logic [ctrq_pkg::BUDGET_W-1:0]        drained;

	assign head_hit = head_live && (head_id == rid_q);

	assign charge_sum = {1'b0, budget_q}
		+ (ctrq_pkg::BUDGET_W + 1)'(ctrq_pkg::charge_cost(nodes_q));
	assign charged = charge_sum[ctrq_pkg::BUDGET_W] ? '1 : charge_sum[ctrq_pkg::BUDGET_W-1:0];

	assign drained = (drain_s1 >= ctrq_pkg::DRAIN_W'(budget_q)) ? '0
		: budget_q - drain_s1[ctrq_pkg::BUDGET_W-1:0];

	// During a walk the slot leaving the head wraps to the tail; a cancel
	// clears it if its id matches. A pop always drops the head slot's live bit.
	always_comb begin
		cmd.shift     = (state_q == S_SCAN) || ((state_q == S_SKIP) && (count_q != '0));
		cmd.wrap_kill = (state_q == S_SCAN) ? ((mode_q == ctrq_pkg::MODE_CANCEL) && head_hit)
			: 1'b1;
		cmd.load      = (state_q == S_ENQ) && !dup_q;
		cmd.load_id   = rid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= ctrq_pkg::BUDGET_LIMIT_RST;
			decay_q <= ctrq_pkg::DECAY_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				ctrq_pkg::CFG_BUDGET_LIMIT: limit_q <= cfg_wdata;
				ctrq_pkg::CFG_DECAY_PER_MS: decay_q <= cfg_wdata[ctrq_pkg::DECAY_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			rid_q   <= requester_id;
			now_q   <= now_ms;
			nodes_q <= nodes_used;
		end
		if (state_q == S_DISPATCH) begin
			drain_s1 <= ctrq_pkg::DRAIN_W'(now_q - last_tick_q) * ctrq_pkg::DRAIN_W'(decay_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= ctrq_pkg::MODE_REQUEST;
			last_tick_q  <= '0;
			budget_q     <= '0;
			count_q      <= '0;
			scan_q       <= '0;
			dup_q        <= 1'b0;
			res_status_q <= ctrq_pkg::ST_NONE;
			res_gid_q    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ctrq_pkg::ST_NONE;
			out_gid_q    <= '0;
		end else begin
			// The final state reloads the result register itself.
			if (out_ready && (state_q != S_DONE))
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q       <= ctrq_pkg::mode_t'(mode);
						res_status_q <= ctrq_pkg::ST_NONE;
						res_gid_q    <= '0;
						state_q      <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					scan_q <= '0;
					dup_q  <= 1'b0;
					case (mode_q)
						ctrq_pkg::MODE_REQUEST: begin
							if ((budget_q > limit_q) || (count_q != '0)) begin
								if (count_q == COUNT_FULL) begin
									res_status_q <= ctrq_pkg::ST_FULL;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_SCAN;
								end
							end else begin
								res_status_q <= ctrq_pkg::ST_GRANTED;
								res_gid_q    <= rid_q;
								state_q      <= S_DONE;
							end
						end
						ctrq_pkg::MODE_TICK: begin
							last_tick_q <= now_q;
							state_q     <= S_DRAIN;
						end
						ctrq_pkg::MODE_CHARGE: begin
							budget_q <= charged;
							state_q  <= S_DONE;
						end
						ctrq_pkg::MODE_CANCEL: begin
							state_q <= S_SCAN;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_SCAN: begin
					if (head_hit)
						dup_q <= 1'b1;
					if (scan_q == SCAN_LAST) begin
						state_q <= (mode_q == ctrq_pkg::MODE_REQUEST) ? S_ENQ : S_DONE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_ENQ: begin
					if (dup_q) begin
						res_status_q <= ctrq_pkg::ST_DUPLICATE;
					end else begin
						res_status_q <= ctrq_pkg::ST_QUEUED;
						count_q      <= count_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DRAIN: begin
					budget_q <= drained;
					state_q  <= (drained <= limit_q) ? S_SKIP : S_DONE;
				end
				S_SKIP: begin
					// Cancelled slots at the head are dropped one per cycle.
					if (count_q == '0) begin
						state_q <= S_DONE;
					end else if (!head_live) begin
						count_q <= count_q - 1'b1;
					end else begin
						count_q      <= count_q - 1'b1;
						res_status_q <= ctrq_pkg::ST_GRANTED;
						res_gid_q    <= head_id;
						state_q      <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_gid_q    <= res_gid_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign granted_id = out_gid_q;
	assign count      = count_q;

endmodule

// ===== rtl/core/credit_throttled_request_queue.sv =====
// ----------------------------------------------------------------------------
// credit_throttled_request_queue
// Leaky-bucket admission queue: grants requests while the cost budget is
// at or under the limit and none waits, else queues new ones if not full.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                           Direction
//   in        in_valid/in_ready, mode, requester_id,           into block
//             now_ms, nodes_used
//   out       out_valid/out_ready, status, granted_id           out of block
//   cfg       cfg_we, cfg_addr, cfg_wdata                       into block
//
// One beat in gives one beat out. A queued request, a duplicate and a
// cancel rotate the chain once past its head; charge, immediate grants and
// full-queue rejects do not. A tick that leaves the budget at or under the
// limit then drops each cancelled slot at the head and grants the first live
// one, if any. One beat is worked on at a time; a new beat is taken while
// the previous result still waits in the output register. Reset empties the
// queue and clears the budget at once. A stalled output holds the sequencer
// in its final state until the result register frees.
module credit_throttled_request_queue #(
	parameter int QUEUE_DEPTH = ctrq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        mode,
	input  logic [ctrq_pkg::ID_W-1:0]         requester_id,
	input  logic [ctrq_pkg::TIME_W-1:0]       now_ms,
	input  logic [ctrq_pkg::NODES_W-1:0]      nodes_used,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ctrq_pkg::STATUS_W-1:0]     status,
	output logic [ctrq_pkg::ID_W-1:0]         granted_id,
	input  logic                              cfg_we,
	input  logic [ctrq_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [ctrq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	ctrq_pkg::cell_cmd_t           cmd;
	logic [CW-1:0]                 count;
	logic [ctrq_pkg::ID_W-1:0]     cell_id   [QUEUE_DEPTH];
	logic                          cell_live [QUEUE_DEPTH];

	ctrq_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CW          (CW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.requester_id (requester_id),
		.now_ms       (now_ms),
		.nodes_used   (nodes_used),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.granted_id   (granted_id),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.head_id      (cell_id[0]),
		.head_live    (cell_live[0]),
		.cmd          (cmd),
		.count        (count)
	);

	// Slot 0 is the head; each slot shifts toward it and the head wraps to
	// the far end of the chain.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		localparam int NB = (i == QUEUE_DEPTH - 1) ? 0 : i + 1;

		ctrq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.sel     (count == CW'(i)),
			.nb_id   (cell_id[NB]),
			.nb_live (cell_live[NB]),
			.nb_kill ((i == QUEUE_DEPTH - 1) ? cmd.wrap_kill : 1'b0),
			.id      (cell_id[i]),
			.live    (cell_live[i])
		);
	end

endmodule

// ===== rtl/core/ctrq_checker.sv =====
// ----------------------------------------------------------------------------
// ctrq_checker
// Port-level checks of the request queue, bound to the top level.
// ----------------------------------------------------------------------------
module ctrq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [ctrq_pkg::STATUS_W-1:0]     status,
	input logic [ctrq_pkg::ID_W-1:0]         granted_id
);

	// A result beat that is held back keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(granted_id))
		else $error("result changed while stalled");

	// Only a grant carries a requester id.
	a_gid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ctrq_pkg::ST_GRANTED) |-> granted_id == '0)
		else $error("granted_id set without a grant");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ctrq_pkg::ST_FULL)
		else $error("status code out of range");

	// One beat is in work at a time: an accepted beat closes the input.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a beat is in work");

	// A new result rises only out of work, when the input was closed before it.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without work");

endmodule

bind credit_throttled_request_queue ctrq_checker u_ctrq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.granted_id (granted_id)
);
